// ===== hdl/tdh_pkg.sv =====
// ----------------------------------------------------------------------------
// tdh_pkg: shared types and constants for the 2-D histogram accumulator
// Sizes of the cell store, field widths, register indexes, beat types and
// the saturating adders used by the update engine.
// ----------------------------------------------------------------------------
package tdh_pkg;

   // Store geometry
   localparam int MAX_COLUMNS    = 64;
   localparam int MAX_ROWS       = 1024;
   localparam int CELL_BITS      = 32;
   localparam int COL_BITS       = $clog2(MAX_COLUMNS);
   localparam int ROW_BITS       = $clog2(MAX_ROWS);
   localparam int CELL_ADDR_BITS = COL_BITS + ROW_BITS;
   localparam int CELL_DEPTH     = 1 << CELL_ADDR_BITS;
   localparam int PEAK_DEPTH     = 1 << COL_BITS;

   // Fixed field widths
   localparam int AMOUNT_BITS = 32;
   localparam int COUNT_BITS  = 32;
   localparam int TOTAL_BITS  = 64;
   localparam int SAT_BITS    = ((CELL_BITS > AMOUNT_BITS) ? CELL_BITS : AMOUNT_BITS) + 1;

   // Configuration registers
   localparam int COLS_REG_BITS  = 7;
   localparam int ROWS_REG_BITS  = 11;
   localparam int CSR_DATA_BITS  = 11;
   localparam int CSR_INDEX_BITS = 1;

   localparam logic [CSR_INDEX_BITS-1:0] REG_COLUMNS_IN_USE = 1'b0;
   localparam logic [CSR_INDEX_BITS-1:0] REG_ROWS_IN_USE    = 1'b1;

   localparam logic [COLS_REG_BITS-1:0] COLS_RESET = 7'd64;
   localparam logic [ROWS_REG_BITS-1:0] ROWS_RESET = 11'd1024;

   localparam logic [CELL_BITS-1:0]  CELL_MAX  = {CELL_BITS{1'b1}};
   localparam logic [TOTAL_BITS-1:0] TOTAL_MAX = {TOTAL_BITS{1'b1}};

   // Input beat
   typedef struct packed {
      logic [COL_BITS-1:0]    column;
      logic [ROW_BITS-1:0]    row;
      logic [AMOUNT_BITS-1:0] amount;
   } req_type;

   // Result beat
   typedef struct packed {
      logic                   accepted;
      logic [COUNT_BITS-1:0]  cell_count;
      logic [TOTAL_BITS-1:0]  total_count;
      logic [COL_BITS-1:0]    peak_column;
   } rsp_type;

   // Acceptance limits
   typedef struct packed {
      logic [COLS_REG_BITS-1:0] columns_in_use;
      logic [ROWS_REG_BITS-1:0] rows_in_use;
   } cfg_type;

   // Cell plus amount, sticking at all ones
   function automatic logic [CELL_BITS-1:0] sat_cell(input logic [CELL_BITS-1:0]   cell_value,
                                                      input logic [AMOUNT_BITS-1:0] amount);
      logic [SAT_BITS-1:0] sum;
      sum = SAT_BITS'(cell_value) + SAT_BITS'(amount);
      if (sum > SAT_BITS'(CELL_MAX)) begin
         return CELL_MAX;
      end
      return sum[CELL_BITS-1:0];
   endfunction

   // Grand total plus amount, sticking at all ones
   function automatic logic [TOTAL_BITS-1:0] sat_total(input logic [TOTAL_BITS-1:0]  total,
                                                        input logic [AMOUNT_BITS-1:0] amount);
      logic [TOTAL_BITS:0] sum;
      sum = {1'b0, total} + (TOTAL_BITS + 1)'(amount);
      if (sum[TOTAL_BITS]) begin
         return TOTAL_MAX;
      end
      return sum[TOTAL_BITS-1:0];
   endfunction

endpackage

// ===== hdl/two_d_histogram_accumulator.sv =====
// ----------------------------------------------------------------------------
// two_d_histogram_accumulator: event histogram over columns and rows
// Adds each event's amount to one cell of a column x row store with
// saturation, keeps the grand total and the column holding the top peak.
//
// Usage:
//   req_*  : one event per beat (column, row, amount), valid/stall.
//   rsp_*  : one result per event, in order (accepted, cell_count,
//            total_count, peak_column), valid/stall.
//   csr_*  : write-only limits: index 0 columns_in_use, index 1
//            rows_in_use. Write only while no event is in flight.
//   A taken event passes the engine's read, calc and done steps; its result
//   loads into the output register from done. Events are taken one at a
//   time, each through the read / add / write-back / peak-compare sequence.
//   Reset: synchronous; afterward the cell and peak stores are swept to
//   zero, one cell per cycle over the whole store, with req_stall high.
//   Limits return to 64 columns and 1024 rows.
//   rsp_stall: the output register holds its beat; the engine processes
//   the next event and waits at its last step until the register frees.
// ----------------------------------------------------------------------------
module two_d_histogram_accumulator import tdh_pkg::*; (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  req_type                   req_data,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output rsp_type                   rsp_data,
   input  logic                      csr_write,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [CSR_DATA_BITS-1:0]  csr_wdata
);

   cfg_type cfg_ff;
   logic    rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_data_ff;
   logic    res_valid, res_free, load;
   rsp_type res_data;

   // Limit registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.columns_in_use <= COLS_RESET;
         cfg_ff.rows_in_use    <= ROWS_RESET;
      end else if (csr_write) begin
         unique case (csr_index)
            REG_COLUMNS_IN_USE: cfg_ff.columns_in_use <= csr_wdata[COLS_REG_BITS-1:0];
            REG_ROWS_IN_USE:    cfg_ff.rows_in_use    <= csr_wdata[ROWS_REG_BITS-1:0];
            default: ;
         endcase
      end
   end

   tdh_engine u_engine (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .res_valid (res_valid),
      .res_free  (res_free),
      .res_data  (res_data)
   );

   // Output register
   assign res_free = !rsp_valid_ff || !rsp_stall;
   assign load     = res_valid && res_free;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (load) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         rsp_data_ff <= res_data;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

// ===== hdl/tdh_ram.sv =====
// ----------------------------------------------------------------------------
// tdh_ram: generic single-write, single-read synchronous RAM
// One write port, one read port, read data registered.
// Read data holds until the next read.
// ----------------------------------------------------------------------------
module tdh_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hdl/tdh_engine.sv =====
// ----------------------------------------------------------------------------
// tdh_engine: read-modify-write sequencer over the cell and peak stores
// Clears both stores after reset, then takes one event at a time: read the
// cell and column peak, add with saturation, write back, track best column.
// ----------------------------------------------------------------------------
module tdh_engine import tdh_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  cfg_type cfg,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    res_valid,
   input  logic    res_free,
   output rsp_type res_data
);

   localparam logic [2:0] ST_CLEAR = 3'd0;
   localparam logic [2:0] ST_IDLE  = 3'd1;
   localparam logic [2:0] ST_READ  = 3'd2;
   localparam logic [2:0] ST_CALC  = 3'd3;
   localparam logic [2:0] ST_DONE  = 3'd4;

   logic [2:0]                state_ff, state_in;
   logic [CELL_ADDR_BITS-1:0] clr_addr_ff, clr_addr_in;

   // Event in flight
   logic [COL_BITS-1:0]    col_ff;
   logic [ROW_BITS-1:0]    row_ff;
   logic [AMOUNT_BITS-1:0] amount_ff;
   logic                   ok_ff;
   logic [CELL_BITS-1:0]   cell_ff, cell_in;
   logic [CELL_BITS-1:0]   peak_ff, peak_in;

   // Global state
   logic [TOTAL_BITS-1:0] total_ff, total_in;
   logic [COL_BITS-1:0]   best_ff, best_in;
   logic [CELL_BITS-1:0]  best_peak_ff, best_peak_in;

   // Memory ports
   logic                      cell_wr_en, peak_wr_en;
   logic [CELL_ADDR_BITS-1:0] cell_wr_addr;
   logic [COL_BITS-1:0]       peak_wr_addr;
   logic [CELL_BITS-1:0]      cell_wr_data, peak_wr_data;
   logic [CELL_BITS-1:0]      cell_rd_data, peak_rd_data;

   logic accept, in_range, handoff, promote;

   assign accept  = req_valid && !req_stall;
   assign handoff = (state_ff == ST_DONE) && res_free;

   // Column and row against the configured limits (and the store size)
   assign in_range = (COLS_REG_BITS'(req_data.column) < cfg.columns_in_use)
                  && (32'(req_data.column) < MAX_COLUMNS)
                  && (ROWS_REG_BITS'(req_data.row) < cfg.rows_in_use)
                  && (32'(req_data.row) < MAX_ROWS);

   assign req_stall = (state_ff != ST_IDLE);

   // Cell store: column-major, one word per cell
   tdh_ram #(
      .WIDTH (CELL_BITS),
      .DEPTH (CELL_DEPTH)
   ) u_cell_ram (
      .clock   (clock),
      .wr_en   (cell_wr_en),
      .wr_addr (cell_wr_addr),
      .wr_data (cell_wr_data),
      .rd_en   (accept),
      .rd_addr ({req_data.column, req_data.row}),
      .rd_data (cell_rd_data)
   );

   // Largest cell of each column
   tdh_ram #(
      .WIDTH (CELL_BITS),
      .DEPTH (PEAK_DEPTH)
   ) u_peak_ram (
      .clock   (clock),
      .wr_en   (peak_wr_en),
      .wr_addr (peak_wr_addr),
      .wr_data (peak_wr_data),
      .rd_en   (accept),
      .rd_addr (req_data.column),
      .rd_data (peak_rd_data)
   );

   // Write ports: clearing sweep or write-back of the event
   always_comb begin
      if (state_ff == ST_CLEAR) begin
         cell_wr_en   = 1'b1;
         cell_wr_addr = clr_addr_ff;
         cell_wr_data = '0;
         peak_wr_en   = 1'b1;
         peak_wr_addr = clr_addr_ff[COL_BITS-1:0];
         peak_wr_data = '0;
      end else begin
         cell_wr_en   = (state_ff == ST_CALC) && ok_ff;
         cell_wr_addr = {col_ff, row_ff};
         cell_wr_data = cell_ff;
         peak_wr_en   = (state_ff == ST_CALC) && ok_ff;
         peak_wr_addr = col_ff;
         peak_wr_data = peak_in;
      end
   end

   // Best column moves only on a strictly greater peak
   assign promote = ok_ff && (peak_ff > best_peak_ff);

   always_comb begin
      state_in     = state_ff;
      clr_addr_in  = clr_addr_ff;
      cell_in      = cell_ff;
      peak_in      = peak_ff;
      total_in     = total_ff;
      best_in      = best_ff;
      best_peak_in = best_peak_ff;

      unique case (state_ff)
         ST_CLEAR: begin
            clr_addr_in = clr_addr_ff + 1'b1;
            if (&clr_addr_ff) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (accept) begin
               state_in = ST_READ;
            end
         end
         ST_READ: begin
            cell_in = sat_cell(cell_rd_data, amount_ff);
            if (ok_ff) begin
               total_in = sat_total(total_ff, amount_ff);
            end
            state_in = ST_CALC;
         end
         ST_CALC: begin
            peak_in  = (cell_ff > peak_rd_data) ? cell_ff : peak_rd_data;
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (promote) begin
               best_in      = col_ff;
               best_peak_in = peak_ff;
            end
            if (res_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control and global state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_addr_ff  <= '0;
         total_ff     <= '0;
         best_ff      <= '0;
         best_peak_ff <= '0;
         ok_ff        <= 1'b0;
      end else begin
         state_ff    <= state_in;
         clr_addr_ff <= clr_addr_in;
         total_ff    <= total_in;
         if (handoff) begin
            best_ff      <= best_in;
            best_peak_ff <= best_peak_in;
         end
         if (accept) begin
            ok_ff <= in_range;
         end
      end
   end

   // Event payload
   always_ff @(posedge clock) begin
      if (accept) begin
         col_ff    <= req_data.column;
         row_ff    <= req_data.row;
         amount_ff <= req_data.amount;
      end
      cell_ff <= cell_in;
      peak_ff <= peak_in;
   end

   // Result beat
   assign res_valid            = (state_ff == ST_DONE);
   assign res_data.accepted    = ok_ff;
   assign res_data.cell_count  = ok_ff ? COUNT_BITS'(cell_ff) : '0;
   assign res_data.total_count = total_ff;
   assign res_data.peak_column = best_in;

endmodule

// ===== dv/histogram_checker.sv =====
// ----------------------------------------------------------------------------
// histogram_checker: prediction and comparison for the 2-D histogram
// Watches the event, result and register ports of the accumulator. Each
// event beat is run through an independent model of the cell store, the
// column peaks, the grand total and the leading column. Each result beat
// is then compared field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module histogram_checker import tdh_pkg::*; (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   input  logic                      req_stall,
   input  req_type                   req_data,
   input  logic                      rsp_valid,
   input  logic                      rsp_stall,
   input  rsp_type                   rsp_data,
   input  logic                      csr_write,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [CSR_DATA_BITS-1:0]  csr_wdata,
   output int                        mismatches,
   output int                        pending
);
   timeunit 1ns;
   timeprecision 1ps;

   // Model state
   logic [CELL_BITS-1:0]     bin_store [CELL_DEPTH];
   logic [CELL_BITS-1:0]     column_peak [MAX_COLUMNS];
   logic [TOTAL_BITS-1:0]    running_total;
   logic [COL_BITS-1:0]      leading_column;
   logic [COLS_REG_BITS-1:0] columns_reg;
   logic [ROWS_REG_BITS-1:0] rows_reg;
   rsp_type                  predicted_q [$];
   rsp_type                  want;

   initial begin
      mismatches = 0;
      pending    = 0;
   end

   // Apply one event to the model and return the result it should produce
   function automatic rsp_type tally_event(req_type ev);
      rsp_type                   outcome;
      int                        col_lim;
      int                        row_lim;
      logic [CELL_ADDR_BITS-1:0] addr;
      logic [CELL_BITS:0]        bin_sum;
      logic [CELL_BITS-1:0]      bin_after;
      logic [TOTAL_BITS:0]       total_sum;
      // limits above the store size clamp to it
      col_lim = (int'(columns_reg) > MAX_COLUMNS) ? MAX_COLUMNS : int'(columns_reg);
      row_lim = (int'(rows_reg) > MAX_ROWS) ? MAX_ROWS : int'(rows_reg);
      outcome = '0;
      if (int'(ev.column) < col_lim && int'(ev.row) < row_lim) begin
         addr      = {ev.column, ev.row};
         bin_sum   = {1'b0, bin_store[addr]} + (CELL_BITS + 1)'(ev.amount);
         bin_after = bin_sum[CELL_BITS] ? CELL_MAX : bin_sum[CELL_BITS-1:0];
         bin_store[addr] = bin_after;
         total_sum = {1'b0, running_total} + (TOTAL_BITS + 1)'(ev.amount);
         running_total = total_sum[TOTAL_BITS] ? TOTAL_MAX : total_sum[TOTAL_BITS-1:0];
         if (bin_after > column_peak[ev.column]) begin
            column_peak[ev.column] = bin_after;
         end
         // ties keep the current leader
         if (column_peak[ev.column] > column_peak[leading_column]) begin
            leading_column = ev.column;
         end
         outcome.accepted   = 1'b1;
         outcome.cell_count = COUNT_BITS'(bin_after);
      end
      outcome.total_count = running_total;
      outcome.peak_column = leading_column;
      return outcome;
   endfunction

   // Results are checked before the same edge's event is predicted
   always @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < CELL_DEPTH; i++) begin
            bin_store[i] = '0;
         end
         for (int i = 0; i < MAX_COLUMNS; i++) begin
            column_peak[i] = '0;
         end
         running_total  = '0;
         leading_column = '0;
         columns_reg    = COLS_RESET;
         rows_reg       = ROWS_RESET;
         predicted_q.delete();
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (predicted_q.size() == 0) begin
               $error("result beat with no event outstanding");
               mismatches++;
            end else begin
               want = predicted_q.pop_front();
               if (rsp_data.accepted !== want.accepted) begin
                  $error("accepted: expected %0d, got %0d", want.accepted, rsp_data.accepted);
                  mismatches++;
               end
               if (rsp_data.cell_count !== want.cell_count) begin
                  $error("cell_count: expected %0h, got %0h",
                         want.cell_count, rsp_data.cell_count);
                  mismatches++;
               end
               if (rsp_data.total_count !== want.total_count) begin
                  $error("total_count: expected %0h, got %0h",
                         want.total_count, rsp_data.total_count);
                  mismatches++;
               end
               if (rsp_data.peak_column !== want.peak_column) begin
                  $error("peak_column: expected %0d, got %0d",
                         want.peak_column, rsp_data.peak_column);
                  mismatches++;
               end
            end
         end
         if (csr_write) begin
            if (csr_index == REG_COLUMNS_IN_USE) begin
               columns_reg = csr_wdata[COLS_REG_BITS-1:0];
            end else if (csr_index == REG_ROWS_IN_USE) begin
               rows_reg = csr_wdata[ROWS_REG_BITS-1:0];
            end
         end
         if (req_valid && !req_stall) begin
            predicted_q.push_back(tally_event(req_data));
         end
      end
      pending <= predicted_q.size();
   end

endmodule

// ===== dv/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench: stimulus and verdict for the 2-D histogram accumulator
// Sends a directed set of events (edges of the store, saturation, zero
// amounts, peak ties, zero and oversized limits), then random events under
// a series of limit settings with random gaps on both channels. Checking
// is done by histogram_checker alongside the block.
// ----------------------------------------------------------------------------
module testbench;
   timeunit 1ns;
   timeprecision 1ps;
   import tdh_pkg::*;

   logic                      clock     = 1'b0;
   logic                      reset     = 1'b1;
   logic                      req_valid = 1'b0;
   req_type                   req_data  = '0;
   logic                      rsp_stall = 1'b0;
   logic                      csr_write = 1'b0;
   logic [CSR_INDEX_BITS-1:0] csr_index = '0;
   logic [CSR_DATA_BITS-1:0]  csr_wdata = '0;
   logic                      req_stall;
   logic                      rsp_valid;
   rsp_type                   rsp_data;
   int                        mismatches;
   int                        pending;

   // Gap rates in percent, and the limits the block currently applies
   int send_idle_pct  = 0;
   int recv_idle_pct  = 0;
   int columns_active = MAX_COLUMNS;
   int rows_active    = MAX_ROWS;

   always #1 clock = ~clock;

   two_d_histogram_accumulator DUT (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_write (csr_write),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   histogram_checker monitor (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_data   (req_data),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_data   (rsp_data),
      .csr_write  (csr_write),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .mismatches (mismatches),
      .pending    (pending)
   );

   // Result-side back-pressure
   always @(posedge clock) begin
      rsp_stall <= !reset && ($urandom_range(99) < recv_idle_pct);
   end

   // One event beat, after an optional random gap
   task automatic send_event(input logic [COL_BITS-1:0]    col,
                             input logic [ROW_BITS-1:0]    row,
                             input logic [AMOUNT_BITS-1:0] amount);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= '{column: col, row: row, amount: amount};
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   // Hold off events until every result is back, then let the pipe settle
   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   // Program both limits while the block is idle
   task automatic write_limits(input int cols, input int rows);
      drain();
      csr_write <= 1'b1;
      csr_index <= REG_COLUMNS_IN_USE;
      csr_wdata <= CSR_DATA_BITS'(cols);
      @(posedge clock);
      csr_index <= REG_ROWS_IN_USE;
      csr_wdata <= CSR_DATA_BITS'(rows);
      @(posedge clock);
      csr_write <= 1'b0;
      columns_active = (cols > MAX_COLUMNS) ? MAX_COLUMNS : cols;
      rows_active    = (rows > MAX_ROWS) ? MAX_ROWS : rows;
   endtask

   // Mostly in-range events; the rest land anywhere and are often rejected
   task automatic send_random_event();
      logic [COL_BITS-1:0]    col;
      logic [ROW_BITS-1:0]    row;
      logic [AMOUNT_BITS-1:0] amount;
      int                     pick;
      col = COL_BITS'($urandom);
      row = ROW_BITS'($urandom);
      if ($urandom_range(99) < 85 && columns_active > 0 && rows_active > 0) begin
         col = COL_BITS'($urandom_range(columns_active - 1));
         row = ROW_BITS'($urandom_range(rows_active - 1));
      end
      pick = $urandom_range(99);
      if (pick < 40) begin
         amount = 1;
      end else if (pick < 60) begin
         amount = $urandom_range(15);
      end else if (pick < 65) begin
         amount = '0;
      end else if (pick < 85) begin
         amount = $urandom;
      end else begin
         amount = '1 - AMOUNT_BITS'($urandom_range(3));
      end
      send_event(col, row, amount);
   endtask

   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      send_idle_pct = 19;
      recv_idle_pct = 87;

      // Default limits: increments, far corner, zero amount, saturation, ties
      send_event(0, 0, 1);
      send_event(63, 1023, 1);             // ties column 0, leader stays
      send_event(63, 1023, 0);
      send_event(5, 17, 32'hFFFF_FFFF);
      send_event(5, 17, 1);                // stuck at all ones
      send_event(5, 18, 32'hFFFF_FFFF);
      send_event(9, 0, 32'hFFFF_FFFF);     // equal peak in another column
      send_event(0, 0, 32'h8000_0000);
      send_event(0, 0, 32'h7FFF_FFFF);     // carries past the top
      send_event(42, 10'h2AA, 32'h5555_5555);
      send_event(21, 10'h155, 32'hAAAA_AAAA);

      // No columns: everything is rejected
      write_limits(0, 1024);
      send_event(0, 0, 1);
      send_event(63, 1023, 5);

      // Limits past the store size clamp to it
      write_limits(127, 2047);
      send_event(63, 1023, 7);
      send_event(0, 0, 1);

      // Small window: inside, and one past each edge
      write_limits(5, 7);
      send_event(4, 6, 3);
      send_event(5, 6, 3);
      send_event(4, 7, 3);
      send_event(63, 0, 1);

      write_limits(1, 1);
      send_event(0, 0, 2);
      send_event(1, 0, 1);
      send_event(0, 1, 1);

      // No rows
      write_limits(64, 0);
      send_event(0, 0, 1);

      // Random phases under varied limits and gap patterns
      for (int phase = 0; phase < 6; phase++) begin
         case (phase / 2)
            0: begin
               send_idle_pct = 19;
               recv_idle_pct = 87;
            end
            1: begin
               send_idle_pct = 87;
               recv_idle_pct = 19;
            end
            default: begin
               send_idle_pct = 0;
               recv_idle_pct = 0;
            end
         endcase
         case (phase % 4)
            0: write_limits($urandom_range(1, 8), $urandom_range(1, 16));
            1: write_limits(MAX_COLUMNS, MAX_ROWS);
            2: write_limits($urandom_range(1, 127), $urandom_range(1, 2047));
            default: write_limits($urandom_range(65, 127), $urandom_range(1025, 2047));
         endcase
         for (int n = 0; n < 84; n++) begin
            // pause mid-phase until the pipe is empty
            if (n == 42) begin
               drain();
            end
            send_random_event();
         end
      end

      drain();
      if (mismatches == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

   // Watchdog: covers the post-reset store sweep and worst-case gaps
   initial begin
      #2_000_000;
      $display("*** FAILED ***");
      $finish;
   end

endmodule

// ===== filelist.f =====
hdl/tdh_pkg.sv
hdl/tdh_ram.sv
hdl/tdh_engine.sv
hdl/two_d_histogram_accumulator.sv
dv/histogram_checker.sv
dv/testbench.sv
